// File: rtl/core/cbr_pkg.sv
// Shared types and constants for the cell bitmap line rasterizer.
package cbr_pkg;

    localparam int X_W    = 9;
    localparam int Y_W    = 8;
    localparam int OFF_W  = 13;
    localparam int ERR_W  = 11;
    localparam int ADDR_W = 16;
    localparam int MASK_W = 8;

    localparam logic [MASK_W-1:0] MASK_LEFT  = 8'h80;
    localparam logic [MASK_W-1:0] MASK_RIGHT = 8'h01;

    localparam logic [OFF_W-1:0] CELL_STEP  = 13'd8;
    localparam logic [OFF_W-1:0] CELL_CROSS = 13'd313;
    localparam logic [OFF_W-1:0] ROW_STEP   = 13'd1;

    localparam logic [ADDR_W-1:0] BITMAP_BASE_RESET = 16'h2000;

    // Register index decoded from paddr[2]
    localparam logic REG_BITMAP_BASE = 1'b0;

    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_ERASE = 2'd2
    } cmd_e;

    typedef struct packed {
        logic [1:0]     command;
        logic [X_W-1:0] x_start;
        logic [Y_W-1:0] y_start;
        logic [X_W-1:0] x_end;
        logic [Y_W-1:0] y_end;
    } cbr_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [MASK_W-1:0] pixel_mask;
        logic              last_pixel;
        logic              from_erase;
    } cbr_out_t;

    // Bresenham pen: position, direction, error and bitmap pointer
    typedef struct packed {
        logic [X_W-1:0]          cur_x;
        logic [Y_W-1:0]          cur_y;
        logic [X_W-1:0]          goal_x;
        logic [Y_W-1:0]          goal_y;
        logic [X_W-1:0]          abs_dx;
        logic [Y_W-1:0]          abs_dy;
        logic                    x_goes_left;
        logic                    y_goes_up;
        logic signed [ERR_W-1:0] error_term;
        logic [OFF_W-1:0]        byte_offset;
        logic [MASK_W-1:0]       bit_mask;
    } pen_t;

    // One dirty list entry
    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [MASK_W-1:0] mask;
    } entry_t;

endpackage

// File: rtl/core/cbr_advance.sv
// One Bresenham step of the pen, with cell-layout pointer update.
module cbr_advance (
    input  cbr_pkg::pen_t pen_i,
    output cbr_pkg::pen_t pen_o,
    output logic          at_goal
);
    import cbr_pkg::*;

    logic signed [ERR_W+1:0] e2;
    logic signed [ERR_W+1:0] ndy;
    logic signed [ERR_W+1:0] pdx;
    logic signed [ERR_W+1:0] err_acc;
    logic                    move_x;
    logic                    move_y;
    logic [MASK_W-1:0]       mask_sh;
    logic [OFF_W-1:0]        off_x;
    logic [OFF_W-1:0]        y_delta;

    always_comb begin
        pen_o   = pen_i;
        e2      = {pen_i.error_term[ERR_W-1], pen_i.error_term, 1'b0};
        ndy     = -$signed({5'b0, pen_i.abs_dy});
        pdx     = $signed({4'b0, pen_i.abs_dx});
        move_x  = (e2 >= ndy);
        move_y  = (e2 <= pdx);
        err_acc = {{2{pen_i.error_term[ERR_W-1]}}, pen_i.error_term};
        off_x   = pen_i.byte_offset;
        mask_sh = pen_i.bit_mask;

        if (move_x) begin
            err_acc = err_acc + ndy;
            if (!pen_i.x_goes_left) begin
                mask_sh = pen_i.bit_mask >> 1;
                if (mask_sh == '0) begin
                    mask_sh = MASK_LEFT;
                    off_x   = pen_i.byte_offset + CELL_STEP;
                end
                pen_o.cur_x = pen_i.cur_x + X_W'(1);
            end else begin
                mask_sh = pen_i.bit_mask << 1;
                if (mask_sh == '0) begin
                    mask_sh = MASK_RIGHT;
                    off_x   = pen_i.byte_offset - CELL_STEP;
                end
                pen_o.cur_x = pen_i.cur_x - X_W'(1);
            end
        end

        pen_o.byte_offset = off_x;
        if (move_y) begin
            err_acc = err_acc + pdx;
            if (!pen_i.y_goes_up) begin
                y_delta           = (pen_i.cur_y[2:0] == 3'd7) ? CELL_CROSS : ROW_STEP;
                pen_o.byte_offset = off_x + y_delta;
                pen_o.cur_y       = pen_i.cur_y + Y_W'(1);
            end else begin
                y_delta           = (pen_i.cur_y[2:0] == 3'd0) ? CELL_CROSS : ROW_STEP;
                pen_o.byte_offset = off_x - y_delta;
                pen_o.cur_y       = pen_i.cur_y - Y_W'(1);
            end
        end else begin
            y_delta = ROW_STEP;
        end

        pen_o.error_term = err_acc[ERR_W-1:0];
        pen_o.bit_mask   = mask_sh;
        at_goal = (pen_o.cur_x == pen_i.goal_x) && (pen_o.cur_y == pen_i.goal_y);
    end

endmodule

// File: rtl/core/cbr_dirty_list.sv
// Dirty list memory: one write port, one registered read port.
module cbr_dirty_list #(
    parameter int DEPTH = 512,
    parameter int IDX_W = 9
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  cbr_pkg::entry_t   wr_data,
    input  logic [IDX_W-1:0]  rd_idx,
    output cbr_pkg::entry_t   rd_data
);
    import cbr_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/cell_bitmap_line_rasterizer.sv
// Top level of the cell bitmap line rasterizer: command decode, pen state and dirty list.
//
// Bresenham line stepper for a 320x200 bitmap laid out in 8x8 character
// cells (320 bytes per cell row, 8 consecutive pixel-row bytes per cell).
// Each input transaction is a command: start draw (loads both endpoints and
// returns the first pixel), step (returns the next pixel of the line, or the
// next recorded pixel during erase replay), or start erase (returns the first
// recorded pixel and arms the replay). A step while idle returns nothing.
// Each result carries bitmap_base plus the cell-layout byte offset, a one-hot
// mask (0x80 is the leftmost pixel), a last flag and an erase flag; toggling
// the byte is up to the consumer. Throughput is one transaction per cycle unless
// the output stalls; a command passes the input register, then the step logic
// into the result register. The dirty list is a LIST_DEPTH entry memory whose read
// port is addressed with the next replay index, so replay also runs at one entry
// per cycle unless the output stalls; entry zero is also held in flops for start
// erase. The list needs no clearing pass after reset. Pixels beyond
// LIST_DEPTH are returned but not recorded. bitmap_base sits at byte address 0
// of the APB port and is sampled when each pixel is returned.
module cell_bitmap_line_rasterizer #(
    parameter int LIST_DEPTH = 512
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    output logic             s_ready,
    input  cbr_pkg::cbr_in_t s_data,

    output logic             m_valid,
    input  logic             m_ready,
    output cbr_pkg::cbr_out_t m_data,

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cbr_pkg::*;

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam pen_t PEN_RESET = '{bit_mask: MASK_LEFT, default: '0};

    // ---------------------------------------------------------------
    // Configuration port: always ready, one register
    // ---------------------------------------------------------------
    logic [ADDR_W-1:0] bitmap_base_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BITMAP_BASE) ? {16'b0, bitmap_base_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitmap_base_reg <= BITMAP_BASE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BITMAP_BASE) begin
            bitmap_base_reg <= pwdata[ADDR_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic              in_valid_reg, in_valid_next;
    cbr_in_t           in_reg;
    logic              out_valid_reg, out_valid_next;
    cbr_out_t          out_reg, out_next;
    pen_t              pen_reg, pen_next;
    logic              drawing_reg, drawing_next;
    logic              erasing_reg, erasing_next;
    logic [CNT_W-1:0]  dirty_count_reg, dirty_count_next;
    logic [CNT_W-1:0]  replay_index_reg, replay_index_next;
    entry_t            first_entry_reg, first_entry_next;

    // Pipeline control: take the held command when the result slot is free
    logic              proc;
    logic              emit;
    logic              emit_last;
    logic              emit_erase;
    entry_t            emit_entry;

    // Dirty list ports
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    entry_t            wr_data;
    entry_t            rd_data;

    // Step logic
    pen_t              pen_adv;
    logic              adv_at_goal;

    // Start draw loads
    logic [X_W-1:0]    ld_dx;
    logic [Y_W-1:0]    ld_dy;
    logic [OFF_W-1:0]  ld_offset;
    logic [MASK_W-1:0] ld_mask;
    logic [4:0]        ld_row;
    logic              ld_last;
    logic [CNT_W-1:0]  replay_inc;

    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    cbr_advance u_advance (
        .pen_i   (pen_reg),
        .pen_o   (pen_adv),
        .at_goal (adv_at_goal)
    );

    // Read address is the next replay index, so the registered entry is ready when the step arrives
    cbr_dirty_list #(
        .DEPTH (LIST_DEPTH),
        .IDX_W (IDX_W)
    ) u_dirty_list (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_idx  (replay_index_next[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Start draw: absolute deltas, first-pixel offset and mask
    always_comb begin
        ld_dx     = (in_reg.x_end > in_reg.x_start) ? in_reg.x_end - in_reg.x_start
                                                    : in_reg.x_start - in_reg.x_end;
        ld_dy     = (in_reg.y_end > in_reg.y_start) ? in_reg.y_end - in_reg.y_start
                                                    : in_reg.y_start - in_reg.y_end;
        ld_row    = in_reg.y_start[7:3];
        // row * 320 as row * 256 + row * 64, wrapping at 13 bits
        ld_offset = OFF_W'({ld_row, 8'b0}) + OFF_W'({ld_row, 6'b0})
                  + OFF_W'({in_reg.x_start[8:3], 3'b000}) + OFF_W'(in_reg.y_start[2:0]);
        ld_mask   = MASK_LEFT >> in_reg.x_start[2:0];
        ld_last   = (in_reg.x_start == in_reg.x_end) && (in_reg.y_start == in_reg.y_end);
    end

    assign replay_inc = replay_index_reg + CNT_ONE;

    // Command decode and state update
    always_comb begin
        pen_next          = pen_reg;
        drawing_next      = drawing_reg;
        erasing_next      = erasing_reg;
        dirty_count_next  = dirty_count_reg;
        replay_index_next = replay_index_reg;
        first_entry_next  = first_entry_reg;
        wr_en             = 1'b0;
        wr_idx            = dirty_count_reg[IDX_W-1:0];
        wr_data           = '{offset: pen_adv.byte_offset, mask: pen_adv.bit_mask};
        emit              = 1'b0;
        emit_last         = 1'b0;
        emit_erase        = 1'b0;
        emit_entry        = rd_data;

        if (proc) begin
            unique case (cmd_e'(in_reg.command))
                CMD_DRAW: begin
                    pen_next.cur_x       = in_reg.x_start;
                    pen_next.cur_y       = in_reg.y_start;
                    pen_next.goal_x      = in_reg.x_end;
                    pen_next.goal_y      = in_reg.y_end;
                    pen_next.abs_dx      = ld_dx;
                    pen_next.abs_dy      = ld_dy;
                    pen_next.x_goes_left = !(in_reg.x_start < in_reg.x_end);
                    pen_next.y_goes_up   = !(in_reg.y_start < in_reg.y_end);
                    pen_next.error_term  = $signed({2'b0, ld_dx}) - $signed({3'b0, ld_dy});
                    pen_next.byte_offset = ld_offset;
                    pen_next.bit_mask    = ld_mask;
                    // Restart the list with the first pixel
                    first_entry_next     = '{offset: ld_offset, mask: ld_mask};
                    wr_en                = 1'b1;
                    wr_idx               = '0;
                    wr_data              = '{offset: ld_offset, mask: ld_mask};
                    dirty_count_next     = CNT_ONE;
                    erasing_next         = 1'b0;
                    drawing_next         = !ld_last;
                    emit                 = 1'b1;
                    emit_last            = ld_last;
                    emit_entry           = '{offset: ld_offset, mask: ld_mask};
                end
                CMD_STEP: begin
                    if (drawing_reg) begin
                        pen_next = pen_adv;
                        // Record while there is room; beyond that, emit only
                        if (dirty_count_reg < CNT_FULL) begin
                            wr_en            = 1'b1;
                            dirty_count_next = dirty_count_reg + CNT_ONE;
                        end
                        drawing_next = !adv_at_goal;
                        emit         = 1'b1;
                        emit_last    = adv_at_goal;
                        emit_entry   = '{offset: pen_adv.byte_offset, mask: pen_adv.bit_mask};
                    end else if (erasing_reg) begin
                        if (replay_index_reg >= dirty_count_reg) begin
                            erasing_next = 1'b0;
                        end else begin
                            replay_index_next = replay_inc;
                            emit_last         = (replay_inc >= dirty_count_reg);
                            erasing_next      = !emit_last;
                            emit              = 1'b1;
                            emit_erase        = 1'b1;
                            emit_entry        = rd_data;
                        end
                    end
                end
                CMD_ERASE: begin
                    drawing_next      = 1'b0;
                    replay_index_next = '0;
                    if (dirty_count_reg == '0) begin
                        erasing_next = 1'b0;
                    end else begin
                        // Entry zero comes from flops; the memory serves the rest
                        replay_index_next = CNT_ONE;
                        emit_last         = (dirty_count_reg == CNT_ONE);
                        erasing_next      = !emit_last;
                        emit              = 1'b1;
                        emit_erase        = 1'b1;
                        emit_entry        = first_entry_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: drop on handshake, load on emit
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next         = 1'b1;
            out_next.pixel_address = bitmap_base_reg + {3'b000, emit_entry.offset};
            out_next.pixel_mask    = emit_entry.mask;
            out_next.last_pixel    = emit_last;
            out_next.from_erase    = emit_erase;
        end
    end

    // Input register: hold the command until the step logic takes it
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pen_reg          <= PEN_RESET;
            drawing_reg      <= 1'b0;
            erasing_reg      <= 1'b0;
            dirty_count_reg  <= '0;
            replay_index_reg <= '0;
        end else begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            pen_reg          <= pen_next;
            drawing_reg      <= drawing_next;
            erasing_reg      <= erasing_next;
            dirty_count_reg  <= dirty_count_next;
            replay_index_reg <= replay_index_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        out_reg         <= out_next;
        first_entry_reg <= first_entry_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_modes_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(drawing_reg && erasing_reg))
        else $error("drawing and erasing both active");

    a_replay_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        erasing_reg |-> (replay_index_reg <= dirty_count_reg
                         && dirty_count_reg <= CNT_FULL))
        else $error("replay index beyond dirty list");

    a_mask_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot(m_data.pixel_mask))
        else $error("pixel mask is not one-hot");

    a_draw_restarts_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_reg.command == CMD_DRAW) |=> (dirty_count_reg == CNT_ONE
                                                  && !erasing_reg && m_valid))
        else $error("start draw did not restart the dirty list");

    a_erase_result_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_erase) |=> (m_valid && m_data.from_erase && !drawing_reg))
        else $error("replayed pixel lost its erase flag");

endmodule
